// ===== src/stl_pkg.sv =====
// Shared types and constants for the script line and word tokenizer.
// Used by the front classifier, the item queue, the back end and the top level.
package stl_pkg;

  localparam int LEN_W  = 10;
  localparam int LINE_W = 16;
  localparam int WCNT_W = 8;
  localparam int VAL_W  = 32;

  localparam int DEFAULT_MAX_LINE_LEN = 1023;
  localparam int DEFAULT_QUEUE_DEPTH  = 4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  typedef enum logic [2:0] {
    CL_OTHER,
    CL_TERM,
    CL_BSLASH,
    CL_QUOTE,
    CL_SPACE
  } cls_t;

  // One classified byte as it travels from front to back.
  typedef struct packed {
    cls_t       cls;
    logic       brk;
    logic       eob;
    logic       is_zero;
    logic       is_x;
    logic       is_digit;
    logic [3:0] digit;
    logic [3:0] nib;
  } stl_item_t;

endpackage

// ===== src/stl_front.sv =====
// Front end: accepts script bytes and classifies each one for the back end.
// Depends on stl_pkg for the item type and character codes.
module stl_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic              end_of_buffer,
  input  logic              q_full,
  output logic              push,
  output stl_pkg::stl_item_t item
);
  import stl_pkg::*;

  logic is_break;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;
  assign is_break = (data_byte == CH_CR) || (data_byte == CH_LF);

  always_comb begin
    item = '0;
    item.eob      = end_of_buffer;
    item.brk      = !end_of_buffer && is_break;
    item.is_zero  = (data_byte == CH_ZERO);
    item.is_x     = (data_byte == CH_X);
    item.is_digit = (data_byte inside {[8'h30:8'h39]});
    item.digit    = data_byte[3:0];
    // Letters a-f and A-F map to 10..15; anything else keeps its low nibble.
    if (data_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      item.nib = data_byte[3:0] + 4'd9;
    end else begin
      item.nib = data_byte[3:0];
    end
    if (end_of_buffer || is_break || data_byte == CH_NUL) begin
      item.cls = CL_TERM;
    end else if (data_byte == CH_BSLASH) begin
      item.cls = CL_BSLASH;
    end else if (data_byte == CH_QUOTE) begin
      item.cls = CL_QUOTE;
    end else if (data_byte == CH_SPACE) begin
      item.cls = CL_SPACE;
    end else begin
      item.cls = CL_OTHER;
    end
  end

endmodule

// ===== src/stl_queue.sv =====
// Short flop-based queue of classified items between front and back.
// Depends on stl_pkg for the item type.
module stl_queue #(
  parameter int DEPTH = stl_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  stl_pkg::stl_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               valid,
  output stl_pkg::stl_item_t item
);
  import stl_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  stl_item_t        slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == FULL_CNT);
  assign valid = (count != '0);
  assign item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/stl_back.sv =====
// Back end: tokenizer state, word value conversion and the output register.
// Depends on stl_pkg; pops classified items from stl_queue.
module stl_back #(
  parameter int MAX_LINE_LEN = stl_pkg::DEFAULT_MAX_LINE_LEN
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  stl_pkg::stl_item_t          q_item,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        kind,
  output logic [stl_pkg::LINE_W-1:0]  line_number,
  output logic [stl_pkg::WCNT_W-1:0]  word_number,
  output logic [stl_pkg::LEN_W-1:0]   word_offset,
  output logic [stl_pkg::LEN_W-1:0]   word_length,
  output logic [stl_pkg::VAL_W-1:0]   number_value,
  output logic                        was_hex,
  output logic [stl_pkg::LEN_W-1:0]   line_length,
  output logic                        ended_by_break,
  output logic                        last
);
  import stl_pkg::*;

  localparam int CAP_I = (MAX_LINE_LEN < 1023) ? MAX_LINE_LEN : 1023;
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_I);

  typedef enum logic [1:0] {
    PF_NONE,
    PF_ZERO,
    PF_HEX,
    PF_NOT
  } prefix_t;

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] v);
    return (v < LEN_CAP) ? v + 1'b1 : LEN_CAP;
  endfunction

  // Tokenizer state
  logic [LEN_W-1:0]  line_len,    line_len_next;
  logic [LEN_W-1:0]  word_start,  word_start_next;
  logic [LEN_W-1:0]  word_len,    word_len_next;
  logic              esc,         esc_next;
  logic              quotes,      quotes_next;
  logic [LINE_W-1:0] line_count,  line_count_next;
  logic [WCNT_W-1:0] word_count,  word_count_next;
  logic [VAL_W-1:0]  dec_acc,     dec_acc_next;
  logic [VAL_W-1:0]  hex_acc,     hex_acc_next;
  prefix_t           prefix,      prefix_next;

  // Line result held back while its word result goes out first
  logic              pend;
  logic [LINE_W-1:0] pend_line_number;
  logic [WCNT_W-1:0] pend_word_number;
  logic [LEN_W-1:0]  pend_line_length;
  logic              pend_brk;

  logic              can_load;
  logic              has_word;
  logic              has_line;
  logic              add;
  logic              cur_hex;
  logic [WCNT_W-1:0] line_words;
  logic [WCNT_W-1:0] word_count_inc;
  logic [LINE_W-1:0] line_count_inc;
  logic [LEN_W-1:0]  add_len;
  logic [VAL_W-1:0]  add_dec;
  logic [VAL_W-1:0]  add_hex;
  prefix_t           add_prefix;

  assign can_load = !out_valid || !out_stall;
  assign pop      = can_load && !pend && q_valid;
  assign cur_hex  = (prefix == PF_HEX) && (word_len > LEN_W'(2));
  assign word_count_inc = (word_count != '1) ? word_count + 1'b1 : word_count;
  assign line_count_inc = (line_count != '1) ? line_count + 1'b1 : line_count;

  // Appending the current byte to the word
  always_comb begin
    add_prefix = prefix;
    add_hex    = hex_acc;
    if (word_len == '0) begin
      add_prefix = q_item.is_zero ? PF_ZERO : PF_NOT;
    end else if (word_len == LEN_W'(1)) begin
      add_prefix = (prefix == PF_ZERO && q_item.is_x) ? PF_HEX : PF_NOT;
    end else if (prefix == PF_HEX) begin
      add_hex = {hex_acc[VAL_W-5:0], q_item.nib};
    end
    if (q_item.is_digit) begin
      add_dec = (dec_acc << 3) + (dec_acc << 1) + VAL_W'(q_item.digit);
    end else begin
      add_dec = dec_acc;
    end
    add_len = sat_len(word_len);
  end

  always_comb begin
    line_len_next   = line_len;
    word_start_next = word_start;
    word_len_next   = word_len;
    esc_next        = esc;
    quotes_next     = quotes;
    line_count_next = line_count;
    word_count_next = word_count;
    dec_acc_next    = dec_acc;
    hex_acc_next    = hex_acc;
    prefix_next     = prefix;
    has_word        = 1'b0;
    has_line        = 1'b0;
    add             = 1'b0;
    line_words      = word_count;

    if (q_item.cls == CL_TERM) begin
      if (line_len != '0) begin
        has_word = (word_len != '0);
        has_line = 1'b1;
      end
      line_words      = has_word ? word_count_inc : word_count;
      line_len_next   = '0;
      word_start_next = '0;
      word_len_next   = '0;
      esc_next        = 1'b0;
      quotes_next     = 1'b0;
      word_count_next = '0;
      dec_acc_next    = '0;
      hex_acc_next    = '0;
      prefix_next     = PF_NONE;
      if (q_item.eob) begin
        line_count_next = '0;
      end else if (line_len != '0) begin
        line_count_next = line_count_inc;
      end
    end else begin
      case (q_item.cls)
        CL_BSLASH: begin
          esc_next = !esc;
          add      = 1'b1;
        end
        CL_QUOTE: begin
          if (!esc) begin
            quotes_next = !quotes;
          end
          esc_next = 1'b0;
          add      = 1'b1;
        end
        CL_SPACE: begin
          if (!quotes && !esc) begin
            // Split here; drop empty words from repeated spaces
            has_word        = (word_len != '0);
            word_count_next = has_word ? word_count_inc : word_count;
            word_len_next   = '0;
            dec_acc_next    = '0;
            hex_acc_next    = '0;
            prefix_next     = PF_NONE;
            word_start_next = sat_len(line_len);
          end else begin
            esc_next = 1'b0;
            add      = 1'b1;
          end
        end
        default: begin
          esc_next = 1'b0;
          add      = 1'b1;
        end
      endcase
      if (add) begin
        word_len_next = add_len;
        dec_acc_next  = add_dec;
        hex_acc_next  = add_hex;
        prefix_next   = add_prefix;
      end
      line_len_next = sat_len(line_len);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_len   <= '0;
      word_start <= '0;
      word_len   <= '0;
      esc        <= 1'b0;
      quotes     <= 1'b0;
      line_count <= '0;
      word_count <= '0;
      dec_acc    <= '0;
      hex_acc    <= '0;
      prefix     <= PF_NONE;
      out_valid  <= 1'b0;
      pend       <= 1'b0;
    end else if (can_load) begin
      if (pend) begin
        out_valid <= 1'b1;
        pend      <= 1'b0;
      end else if (q_valid) begin
        line_len   <= line_len_next;
        word_start <= word_start_next;
        word_len   <= word_len_next;
        esc        <= esc_next;
        quotes     <= quotes_next;
        line_count <= line_count_next;
        word_count <= word_count_next;
        dec_acc    <= dec_acc_next;
        hex_acc    <= hex_acc_next;
        prefix     <= prefix_next;
        out_valid  <= has_word || has_line;
        pend       <= has_word && has_line;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; no reset needed
  always_ff @(posedge clk) begin
    if (can_load) begin
      if (pend) begin
        kind           <= KIND_LINE;
        line_number    <= pend_line_number;
        word_number    <= pend_word_number;
        word_offset    <= '0;
        word_length    <= '0;
        number_value   <= '0;
        was_hex        <= 1'b0;
        line_length    <= pend_line_length;
        ended_by_break <= pend_brk;
        last           <= 1'b1;
      end else if (q_valid) begin
        pend_line_number <= line_count;
        pend_word_number <= line_words;
        pend_line_length <= line_len;
        pend_brk         <= q_item.brk;
        if (has_word) begin
          kind           <= KIND_WORD;
          line_number    <= line_count;
          word_number    <= word_count;
          word_offset    <= word_start;
          word_length    <= word_len;
          number_value   <= cur_hex ? hex_acc : dec_acc;
          was_hex        <= cur_hex;
          line_length    <= '0;
          ended_by_break <= 1'b0;
          last           <= !has_line;
        end else begin
          kind           <= KIND_LINE;
          line_number    <= line_count;
          word_number    <= line_words;
          word_offset    <= '0;
          word_length    <= '0;
          number_value   <= '0;
          was_hex        <= 1'b0;
          line_length    <= line_len;
          ended_by_break <= q_item.brk;
          last           <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTH
  a_pend_has_output: assert property (@(posedge clk) disable iff (rst)
    pend |-> out_valid)
    else $error("held line result without a word result in the output register");

  a_word_not_last_pend: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_WORD && !last) |-> pend)
    else $error("word result not marked last but no line result held");

  a_line_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == KIND_LINE) |-> last)
    else $error("line result not marked last");

  a_word_within_line: assert property (@(posedge clk) disable iff (rst)
    (line_len == '0) |-> (word_len == '0 && !esc && !quotes))
    else $error("word or escape state open on an empty line");

  a_pend_released: assert property (@(posedge clk) disable iff (rst)
    (pend && !out_stall) |=> (!pend && out_valid && kind == KIND_LINE))
    else $error("held line result not sent after word result was taken");
`endif

endmodule

// ===== src/script_line_word_tokenizer_top.sv =====
// Script line and word tokenizer, top level.
// Path: an accepted byte goes through a queue slot, then the back end output register.
// Throughput: one byte per cycle while the queue is not full; a line end that closes
// an open word gives a word result and then a line result, the queue absorbs the extra one.
// Reset: synchronous, active high; clears counters, queue and output valid.
module script_line_word_tokenizer_top #(
  parameter int MAX_LINE_LEN = stl_pkg::DEFAULT_MAX_LINE_LEN,
  parameter int QUEUE_DEPTH  = stl_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        end_of_buffer,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        kind,
  output logic [stl_pkg::LINE_W-1:0]  line_number,
  output logic [stl_pkg::WCNT_W-1:0]  word_number,
  output logic [stl_pkg::LEN_W-1:0]   word_offset,
  output logic [stl_pkg::LEN_W-1:0]   word_length,
  output logic [stl_pkg::VAL_W-1:0]   number_value,
  output logic                        was_hex,
  output logic [stl_pkg::LEN_W-1:0]   line_length,
  output logic                        ended_by_break,
  output logic                        last
);
  import stl_pkg::*;

  stl_item_t front_item;
  stl_item_t q_item;
  logic      push;
  logic      pop;
  logic      q_full;
  logic      q_valid;

  stl_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_buffer (end_of_buffer),
    .q_full        (q_full),
    .push          (push),
    .item          (front_item)
  );

  stl_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .item      (q_item)
  );

  stl_back #(
    .MAX_LINE_LEN (MAX_LINE_LEN)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .kind           (kind),
    .line_number    (line_number),
    .word_number    (word_number),
    .word_offset    (word_offset),
    .word_length    (word_length),
    .number_value   (number_value),
    .was_hex        (was_hex),
    .line_length    (line_length),
    .ended_by_break (ended_by_break),
    .last           (last)
  );

endmodule
